// ===== design/z80rse_pkg.sv =====
// ----------------------------------------------------------------------------
// z80rse_pkg
// Shared types and constants for the Z80-style register subset executor:
// command codes, flag bit masks, register file and result beat layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package z80rse_pkg;

	// command codes
	localparam logic [4:0] CMD_RLA     = 5'd0;
	localparam logic [4:0] CMD_RRA     = 5'd1;
	localparam logic [4:0] CMD_RLCA    = 5'd2;
	localparam logic [4:0] CMD_RRCA    = 5'd3;
	localparam logic [4:0] CMD_CP      = 5'd4;
	localparam logic [4:0] CMD_SBC_BC  = 5'd5;
	localparam logic [4:0] CMD_SBC_DE  = 5'd6;
	localparam logic [4:0] CMD_SBC_HL  = 5'd7;
	localparam logic [4:0] CMD_SBC_SP  = 5'd8;
	localparam logic [4:0] CMD_ADD_IX  = 5'd9;
	localparam logic [4:0] CMD_ADD_IY  = 5'd10;
	localparam logic [4:0] CMD_EX_DEHL = 5'd11;
	localparam logic [4:0] CMD_EXX     = 5'd12;
	localparam logic [4:0] CMD_EX_AF   = 5'd13;
	localparam logic [4:0] CMD_LD_AI   = 5'd14;
	localparam logic [4:0] CMD_LDI     = 5'd15;
	localparam logic [4:0] CMD_PUSH_AF = 5'd16;
	localparam logic [4:0] CMD_PUSH_BC = 5'd17;
	localparam logic [4:0] CMD_PUSH_DE = 5'd18;
	localparam logic [4:0] CMD_PUSH_HL = 5'd19;
	localparam logic [4:0] CMD_POP_AF  = 5'd20;
	localparam logic [4:0] CMD_POP_BC  = 5'd21;
	localparam logic [4:0] CMD_POP_DE  = 5'd22;
	localparam logic [4:0] CMD_POP_HL  = 5'd23;

	// flag bit masks
	localparam logic [7:0] FL_S  = 8'h80;
	localparam logic [7:0] FL_Z  = 8'h40;
	localparam logic [7:0] FL_H  = 8'h10;
	localparam logic [7:0] FL_PV = 8'h04;
	localparam logic [7:0] FL_N  = 8'h02;
	localparam logic [7:0] FL_C  = 8'h01;

	localparam logic [15:0] SP_RESET = 16'hFFFE;

	// architectural register file
	typedef struct packed {
		logic [7:0]  acc;
		logic [7:0]  flags;
		logic [15:0] bc;
		logic [15:0] de;
		logic [15:0] hl;
		logic [7:0]  acc_sh;
		logic [7:0]  flags_sh;
		logic [15:0] bc_sh;
		logic [15:0] de_sh;
		logic [15:0] hl_sh;
		logic [15:0] sp;
		logic [15:0] ix;
		logic [15:0] iy;
	} regs_t;

	// one result beat
	typedef struct packed {
		logic        write_enable;
		logic [15:0] write_address;
		logic [7:0]  write_data;
		logic [7:0]  acc_value;
		logic [7:0]  flag_value;
		logic [15:0] bc_value;
		logic [15:0] de_value;
		logic [15:0] hl_value;
		logic [15:0] stack_value;
		logic [15:0] ix_value;
		logic [15:0] iy_value;
		logic        last;
	} beat_t;

	// everything one command produces
	typedef struct packed {
		regs_t nxt;
		beat_t beat0;
		beat_t beat1;
		logic  two;
	} exec_t;

endpackage

`default_nettype wire

// ===== design/z80rse_cmd_if.sv =====
// ----------------------------------------------------------------------------
// z80rse_cmd_if
// Command channel: valid/ready handshake with command code and read data.
// ----------------------------------------------------------------------------
`default_nettype none

interface z80rse_cmd_if;
	logic        valid;
	logic        ready;
	logic [4:0]  command;
	logic [15:0] read_data;

	modport source (output valid, output command, output read_data, input ready);
	modport sink   (input valid, input command, input read_data, output ready);
endinterface

`default_nettype wire

// ===== design/z80rse_res_if.sv =====
// ----------------------------------------------------------------------------
// z80rse_res_if
// Result channel: valid/ready handshake with memory write and register view.
// ----------------------------------------------------------------------------
`default_nettype none

interface z80rse_res_if;
	logic        valid;
	logic        ready;
	logic        write_enable;
	logic [15:0] write_address;
	logic [7:0]  write_data;
	logic [7:0]  acc_value;
	logic [7:0]  flag_value;
	logic [15:0] bc_value;
	logic [15:0] de_value;
	logic [15:0] hl_value;
	logic [15:0] stack_value;
	logic [15:0] ix_value;
	logic [15:0] iy_value;
	logic        last;

	modport source (
		output valid, output write_enable, output write_address, output write_data,
		output acc_value, output flag_value, output bc_value, output de_value,
		output hl_value, output stack_value, output ix_value, output iy_value,
		output last, input ready
	);
	modport sink (
		input valid, input write_enable, input write_address, input write_data,
		input acc_value, input flag_value, input bc_value, input de_value,
		input hl_value, input stack_value, input ix_value, input iy_value,
		input last, output ready
	);
endinterface

`default_nettype wire

// ===== design/z80rse_exec.sv =====
// ----------------------------------------------------------------------------
// z80rse_exec
// Command execute logic: computes the next register file and the result
// beats of one command from the current registers and the read data.
// ----------------------------------------------------------------------------
`default_nettype none

module z80rse_exec (
	input  wire logic [4:0]        command,
	input  wire logic [15:0]       read_data,
	input  wire z80rse_pkg::regs_t cur,
	output z80rse_pkg::exec_t      res
);
	import z80rse_pkg::*;

	logic [7:0]  mem_byte;
	logic        c_in;
	logic [8:0]  cp_diff;
	logic [15:0] sbc_src;
	logic [16:0] sbc_diff;
	logic [15:0] add_src;
	logic [16:0] add_sum;
	logic [15:0] bc_dec;
	logic [15:0] push_val;
	logic [15:0] sp_m1;
	logic [15:0] sp_m2;
	logic [7:0]  rot_keep;
	regs_t       nxt;
	logic        two;
	logic        we;
	logic [15:0] wa;
	logic [7:0]  wd;
	logic [15:0] wa2;
	logic [7:0]  wd2;

	assign mem_byte = read_data[7:0];
	assign c_in     = cur.flags[0];
	assign rot_keep = cur.flags & ~(FL_C | FL_N | FL_H);

	// compare and subtract-with-borrow datapaths
	assign cp_diff = {1'b0, cur.acc} - {1'b0, mem_byte};

	always_comb begin
		case (command)
			CMD_SBC_BC: sbc_src = cur.bc;
			CMD_SBC_DE: sbc_src = cur.de;
			CMD_SBC_HL: sbc_src = cur.hl;
			default:    sbc_src = cur.sp;
		endcase
	end

	assign sbc_diff = {1'b0, cur.hl} - {1'b0, sbc_src} - {16'd0, c_in};

	// index add
	assign add_src = (command == CMD_ADD_IX) ? cur.ix : cur.iy;
	assign add_sum = {1'b0, add_src} + {1'b0, cur.sp};

	assign bc_dec = cur.bc - 16'd1;
	assign sp_m1  = cur.sp - 16'd1;
	assign sp_m2  = cur.sp - 16'd2;

	// push source
	always_comb begin
		case (command)
			CMD_PUSH_AF: push_val = {cur.acc, cur.flags};
			CMD_PUSH_BC: push_val = cur.bc;
			CMD_PUSH_DE: push_val = cur.de;
			default:     push_val = cur.hl;
		endcase
	end

	// next state per command
	always_comb begin
		nxt = cur;
		two = 1'b0;
		we  = 1'b0;
		wa  = 16'd0;
		wd  = 8'd0;
		wa2 = 16'd0;
		wd2 = 8'd0;
		case (command)
			CMD_RLA: begin
				nxt.acc   = {cur.acc[6:0], c_in};
				nxt.flags = rot_keep | (cur.acc[7] ? FL_C : 8'd0);
			end
			CMD_RRA: begin
				nxt.acc   = {c_in, cur.acc[7:1]};
				nxt.flags = rot_keep | (cur.acc[0] ? FL_C : 8'd0);
			end
			CMD_RLCA: begin
				nxt.acc   = {cur.acc[6:0], cur.acc[7]};
				nxt.flags = rot_keep | (cur.acc[7] ? FL_C : 8'd0);
			end
			CMD_RRCA: begin
				nxt.acc   = {cur.acc[0], cur.acc[7:1]};
				nxt.flags = rot_keep | (cur.acc[0] ? FL_C : 8'd0);
			end
			CMD_CP: begin
				nxt.flags = FL_N
					| ((cp_diff[7:0] == 8'd0) ? FL_Z : 8'd0)
					| (cp_diff[7] ? FL_S : 8'd0)
					| (cp_diff[8] ? FL_C : 8'd0)
					| ((cur.acc[3:0] < mem_byte[3:0]) ? FL_H : 8'd0);
			end
			CMD_SBC_BC, CMD_SBC_DE, CMD_SBC_HL, CMD_SBC_SP: begin
				nxt.hl    = sbc_diff[15:0];
				nxt.flags = FL_N
					| ((sbc_diff[15:0] == 16'd0) ? FL_Z : 8'd0)
					| (sbc_diff[15] ? FL_S : 8'd0)
					| (sbc_diff[16] ? FL_C : 8'd0);
			end
			CMD_ADD_IX, CMD_ADD_IY: begin
				if (command == CMD_ADD_IX) begin
					nxt.ix = add_sum[15:0];
				end else begin
					nxt.iy = add_sum[15:0];
				end
				nxt.flags = (cur.flags & ~(FL_N | FL_C)) | (add_sum[16] ? FL_C : 8'd0);
			end
			CMD_EX_DEHL: begin
				nxt.de = cur.hl;
				nxt.hl = cur.de;
			end
			CMD_EXX: begin
				nxt.bc    = cur.bc_sh;
				nxt.de    = cur.de_sh;
				nxt.hl    = cur.hl_sh;
				nxt.bc_sh = cur.bc;
				nxt.de_sh = cur.de;
				nxt.hl_sh = cur.hl;
			end
			CMD_EX_AF: begin
				nxt.acc      = cur.acc_sh;
				nxt.flags    = cur.flags_sh;
				nxt.acc_sh   = cur.acc;
				nxt.flags_sh = cur.flags;
			end
			CMD_LD_AI: begin
				nxt.acc   = 8'd0;
				nxt.flags = FL_Z;
			end
			CMD_LDI: begin
				we        = 1'b1;
				wa        = cur.de;
				wd        = mem_byte;
				nxt.hl    = cur.hl + 16'd1;
				nxt.de    = cur.de + 16'd1;
				nxt.bc    = bc_dec;
				nxt.flags = (cur.flags & ~(FL_N | FL_H | FL_PV))
					| ((bc_dec != 16'd0) ? FL_PV : 8'd0);
			end
			CMD_PUSH_AF, CMD_PUSH_BC, CMD_PUSH_DE, CMD_PUSH_HL: begin
				two    = 1'b1;
				we     = 1'b1;
				wa     = sp_m1;
				wd     = push_val[15:8];
				wa2    = sp_m2;
				wd2    = push_val[7:0];
				nxt.sp = sp_m2;
			end
			CMD_POP_AF, CMD_POP_BC, CMD_POP_DE, CMD_POP_HL: begin
				case (command)
					CMD_POP_AF: begin
						nxt.acc   = read_data[15:8];
						nxt.flags = read_data[7:0];
					end
					CMD_POP_BC: nxt.bc = read_data;
					CMD_POP_DE: nxt.de = read_data;
					default:    nxt.hl = read_data;
				endcase
				nxt.sp = cur.sp + 16'd2;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	// result beats, both showing the registers after the whole command
	always_comb begin
		res.nxt                 = nxt;
		res.two                 = two;
		res.beat0.write_enable  = we;
		res.beat0.write_address = wa;
		res.beat0.write_data    = wd;
		res.beat0.acc_value     = nxt.acc;
		res.beat0.flag_value    = nxt.flags;
		res.beat0.bc_value      = nxt.bc;
		res.beat0.de_value      = nxt.de;
		res.beat0.hl_value      = nxt.hl;
		res.beat0.stack_value   = nxt.sp;
		res.beat0.ix_value      = nxt.ix;
		res.beat0.iy_value      = nxt.iy;
		res.beat0.last          = ~two;
		res.beat1               = res.beat0;
		res.beat1.write_enable  = 1'b1;
		res.beat1.write_address = wa2;
		res.beat1.write_data    = wd2;
		res.beat1.last          = 1'b1;
	end

endmodule

`default_nettype wire

// ===== design/z80rse_regs.sv =====
// ----------------------------------------------------------------------------
// z80rse_regs
// Architectural register file: A, F, main and shadow pairs, SP, IX, IY.
// ----------------------------------------------------------------------------
`default_nettype none

module z80rse_regs (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              update,
	input  wire z80rse_pkg::regs_t nxt,
	output z80rse_pkg::regs_t      regs
);
	import z80rse_pkg::*;

	// everything clear except the stack pointer
	localparam regs_t REGS_RESET = '{sp: SP_RESET, default: '0};

	regs_t regs_q;

	// commit the executed command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= REGS_RESET;
		end else if (update) begin
			regs_q <= nxt;
		end
	end

	assign regs = regs_q;

endmodule

`default_nettype wire

// ===== design/z80rse_outbuf.sv =====
// ----------------------------------------------------------------------------
// z80rse_outbuf
// Result register with one extra slot for the second beat of a push.
// ----------------------------------------------------------------------------
`default_nettype none

module z80rse_outbuf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire z80rse_pkg::beat_t beat0,
	input  wire z80rse_pkg::beat_t beat1,
	input  wire logic              two,
	output logic                   can_load,
	z80rse_res_if.source           res
);
	import z80rse_pkg::*;

	beat_t out_q;
	beat_t pend_q;
	logic  out_v_q;
	logic  pend_v_q;
	logic  taken;

	assign taken    = out_v_q & res.ready;
	assign can_load = ~out_v_q | (res.ready & ~pend_v_q);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else if (load) begin
			out_v_q  <= 1'b1;
			pend_v_q <= two;
		end else if (taken) begin
			out_v_q  <= pend_v_q;
			pend_v_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_q  <= beat0;
			pend_q <= beat1;
		end else if (taken && pend_v_q) begin
			out_q <= pend_q;
		end
	end

	assign res.valid         = out_v_q;
	assign res.write_enable  = out_q.write_enable;
	assign res.write_address = out_q.write_address;
	assign res.write_data    = out_q.write_data;
	assign res.acc_value     = out_q.acc_value;
	assign res.flag_value    = out_q.flag_value;
	assign res.bc_value      = out_q.bc_value;
	assign res.de_value      = out_q.de_value;
	assign res.hl_value      = out_q.hl_value;
	assign res.stack_value   = out_q.stack_value;
	assign res.ix_value      = out_q.ix_value;
	assign res.iy_value      = out_q.iy_value;
	assign res.last          = out_q.last;

endmodule

`default_nettype wire

// ===== design/z80_register_subset_executor_core.sv =====
// ----------------------------------------------------------------------------
// z80_register_subset_executor_core
// Z80-style register file with a small command executor.
//
// Usage: the cmd channel takes one command beat (command code and the memory
// read data it needs) per handshake; the res channel gives back one beat per
// command, or two for a push (high byte write to SP-1, then low byte write to
// SP-2, last set on the second). Every beat shows A, F, BC, DE, HL, SP, IX
// and IY after the whole command.
// Path: a command beat is registered at the input register, then executed;
// the register file commits it as the result register loads its first beat,
// which drives res. Execution waits while the result register cannot load.
// Throughput: one command per cycle while res is ready; a push holds the result
// register until both of its beats are taken, and the next command waits.
// Reset: all registers clear, SP goes to 0xFFFE, both channels go empty.
// Stall: while res is not taken the result register holds; one more command
// waits in the input register, then cmd.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module z80_register_subset_executor_core (
	input  wire logic    clk,
	input  wire logic    arst_n,
	z80rse_cmd_if.sink   cmd,
	z80rse_res_if.source res
);
	import z80rse_pkg::*;

	logic        valid_s1;
	logic [4:0]  command_s1;
	logic [15:0] read_data_s1;
	logic        can_load;
	logic        exec_fire;
	regs_t       regs;
	exec_t       ex;

	assign exec_fire = valid_s1 & can_load;
	assign cmd.ready = ~valid_s1 | can_load;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			command_s1   <= cmd.command;
			read_data_s1 <= cmd.read_data;
		end
	end

	// execute
	z80rse_exec u_exec (
		.command   (command_s1),
		.read_data (read_data_s1),
		.cur       (regs),
		.res       (ex)
	);

	// register file
	z80rse_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.update (exec_fire),
		.nxt    (ex.nxt),
		.regs   (regs)
	);

	// result register
	z80rse_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (exec_fire),
		.beat0    (ex.beat0),
		.beat1    (ex.beat1),
		.two      (ex.two),
		.can_load (can_load),
		.res      (res)
	);

	// a non-final beat is always the first write of a push
	a_first_beat_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.last) |-> res.write_enable)
		else $error("non-final result beat without a write");

	// the second push beat follows at once, one address lower
	a_push_second: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.ready && !res.last) |=>
		(res.valid && res.last && res.write_enable &&
		 res.write_address == $past(res.write_address) - 16'd1))
		else $error("second push beat missing or misplaced");

	// a blocked command waits in the input register unchanged
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !can_load) |=>
		(valid_s1 && $stable(command_s1) && $stable(read_data_s1)))
		else $error("stalled command lost from input register");

endmodule

`default_nettype wire
